// ===== src/pdc_pkg.sv =====
// Types and constants shared by the dial collector modules.
// Has no dependencies; the other files that use it refer to it by scoped names.
package pdc_pkg;

    // Input kind codes
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_HOOK    = 2'd1;
    localparam logic [1:0] KIND_TONE    = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // Commands passed from front to back
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_HOOK_ON  = 2'd1;
    localparam logic [1:0] CMD_HOOK_OFF = 2'd2;
    localparam logic [1:0] CMD_TONE     = 2'd3;

    // Line states
    localparam logic [1:0] LINE_INACTIVE = 2'd0;
    localparam logic [1:0] LINE_ACTIVE   = 2'd1;
    localparam logic [1:0] LINE_DOWN     = 2'd2;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGIT_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_TIMEOUT = 2'd1;

    localparam logic [15:0] DIGIT_TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] PULSE_TIMEOUT_RESET = 16'd200;

    // Pulse counts at or above this give digit 0
    localparam logic [3:0] PULSE_WRAP = 4'd10;
    localparam logic [3:0] PULSE_MAX  = 4'd15;

    // Largest number of results one item can cause
    localparam int STORE_CAP = 16;

    typedef struct packed {
        logic [1:0] kind;
        logic       hook_on;
        logic [7:0] tone_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0] digit_value;
        logic [3:0] digit_position;
        logic [4:0] digit_total;
        logic       last_digit;
        logic       store_overflowed;
    } out_item_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] code;
    } cmd_t;

    typedef struct packed {
        logic [15:0] digit_timeout;
        logic [15:0] pulse_timeout;
    } cfg_t;

endpackage

// ===== src/pdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/pdc_queue.sv =====
// Small first-in first-out queue of register entries.
// No dependencies; used for the command queue and the result queue.
module pdc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/pdc_front.sv =====
// Front end: takes input items, turns them into back-end commands.
// Depends on pdc_pkg and pdc_queue.
module pdc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  pdc_pkg::in_item_t item,
    output logic             cmd_valid,
    output pdc_pkg::cmd_t    cmd,
    input  logic             cmd_take
);

    pdc_pkg::cmd_t cmd_in;
    logic          keep;
    logic          q_empty;
    logic [$bits(pdc_pkg::cmd_t)-1:0] q_rdata;

    always_comb
    begin
        keep        = 1'b1;
        cmd_in.code = item.tone_code;
        cmd_in.op   = pdc_pkg::CMD_TICK;
        unique case (item.kind)
            pdc_pkg::KIND_TICK:
            begin
                cmd_in.op = pdc_pkg::CMD_TICK;
            end
            pdc_pkg::KIND_HOOK:
            begin
                cmd_in.op = item.hook_on ? pdc_pkg::CMD_HOOK_ON : pdc_pkg::CMD_HOOK_OFF;
            end
            pdc_pkg::KIND_TONE:
            begin
                cmd_in.op = pdc_pkg::CMD_TONE;
            end
            pdc_pkg::KIND_IGNORED:
            begin
                // accept and drop
                keep = 1'b0;
            end
        endcase
    end

    pdc_queue #(
        .WIDTH($bits(pdc_pkg::cmd_t)),
        .DEPTH(2)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_take),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd       = pdc_pkg::cmd_t'(q_rdata);

endmodule

// ===== src/pdc_back.sv =====
// Back end: line state, timers, digit store and number dump.
// Depends on pdc_pkg, pdc_ram and pdc_queue.
module pdc_back #(
    parameter int MAX_DIGITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pdc_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    input  pdc_pkg::cmd_t      cmd,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output pdc_pkg::out_item_t result
);

    localparam int DEPTH = (MAX_DIGITS < pdc_pkg::STORE_CAP) ? MAX_DIGITS : pdc_pkg::STORE_CAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  line_reg, line_next;
    logic [3:0]  pc_reg, pc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0] dt_reg, dt_next;
    logic        da_reg, da_next;
    logic [15:0] pt_reg, pt_next;
    logic        pa_reg, pa_next;
    logic        ovf_reg, ovf_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] tot_reg, tot_next;
    logic        dovf_reg, dovf_next;

    logic        note;
    logic [7:0]  note_val;
    logic        rearmed;
    logic        dump_start;
    logic        ram_we;
    logic        ram_re;
    logic [7:0]  ram_rdata;
    logic        res_push;
    logic        res_full;
    logic        is_last;
    logic [4:0]  k_wide;
    logic [$bits(pdc_pkg::out_item_t)-1:0] res_rdata;
    pdc_pkg::out_item_t res_item;

    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid;
    assign is_last  = (tot_reg == '0) || (k_reg + CW'(1) == tot_reg);
    assign k_wide   = 5'(k_reg);

    always_comb
    begin
        res_item.digit_value      = (tot_reg == '0) ? 8'd0 : ram_rdata;
        res_item.digit_position   = k_wide[3:0];
        res_item.digit_total      = 5'(tot_reg);
        res_item.last_digit       = is_last;
        res_item.store_overflowed = dovf_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        line_next  = line_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        dt_next    = dt_reg;
        da_next    = da_reg;
        pt_next    = pt_reg;
        pa_next    = pa_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        tot_next   = tot_reg;
        dovf_next  = dovf_reg;
        note       = 1'b0;
        note_val   = cmd.code;
        rearmed    = 1'b0;
        dump_start = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        res_push   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        pdc_pkg::CMD_TICK:
                        begin
                            // pulse timer goes first; a noted digit rearms the digit timer
                            if (pa_reg)
                            begin
                                if (pt_reg <= 16'd1)
                                begin
                                    pt_next = '0;
                                    pa_next = 1'b0;
                                    if (line_reg == pdc_pkg::LINE_DOWN)
                                    begin
                                        line_next = pdc_pkg::LINE_INACTIVE;
                                    end
                                    else
                                    begin
                                        if (pc_reg != '0)
                                        begin
                                            note     = 1'b1;
                                            note_val = (pc_reg < pdc_pkg::PULSE_WRAP) ?
                                                       {4'd0, pc_reg} : 8'd0;
                                            rearmed  = 1'b1;
                                        end
                                        pc_next = '0;
                                    end
                                end
                                else
                                begin
                                    pt_next = pt_reg - 16'd1;
                                end
                            end
                            if (da_reg && !rearmed)
                            begin
                                if (dt_reg <= 16'd1)
                                begin
                                    dump_start = 1'b1;
                                end
                                else
                                begin
                                    dt_next = dt_reg - 16'd1;
                                end
                            end
                        end
                        pdc_pkg::CMD_HOOK_ON:
                        begin
                            if (line_reg == pdc_pkg::LINE_ACTIVE)
                            begin
                                line_next = pdc_pkg::LINE_DOWN;
                                pt_next   = cfg.pulse_timeout;
                                pa_next   = 1'b1;
                            end
                        end
                        pdc_pkg::CMD_HOOK_OFF:
                        begin
                            if (line_reg == pdc_pkg::LINE_INACTIVE)
                            begin
                                line_next = pdc_pkg::LINE_ACTIVE;
                            end
                            else if (line_reg != pdc_pkg::LINE_ACTIVE)
                            begin
                                // back off-hook after a brief on-hook: one dial pulse
                                dt_next   = cfg.digit_timeout;
                                da_next   = 1'b1;
                                line_next = pdc_pkg::LINE_ACTIVE;
                                if (pc_reg != pdc_pkg::PULSE_MAX)
                                begin
                                    pc_next = pc_reg + 4'd1;
                                end
                            end
                        end
                        pdc_pkg::CMD_TONE:
                        begin
                            if (line_reg == pdc_pkg::LINE_ACTIVE)
                            begin
                                note = 1'b1;
                            end
                        end
                    endcase
                end

                if (note)
                begin
                    if (cnt_reg < CW'(DEPTH))
                    begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    dt_next = cfg.digit_timeout;
                    da_next = 1'b1;
                end

                if (dump_start)
                begin
                    // capture the number, then clear all collector state
                    tot_next   = cnt_reg;
                    dovf_next  = ovf_reg;
                    k_next     = '0;
                    state_next = (cnt_reg == '0) ? ST_PUSH : ST_RD;
                    line_next  = pdc_pkg::LINE_INACTIVE;
                    pc_next    = '0;
                    cnt_next   = '0;
                    dt_next    = '0;
                    da_next    = 1'b0;
                    pt_next    = '0;
                    pa_next    = 1'b0;
                    ovf_next   = 1'b0;
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            line_reg  <= pdc_pkg::LINE_INACTIVE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            dt_reg    <= '0;
            da_reg    <= 1'b0;
            pt_reg    <= '0;
            pa_reg    <= 1'b0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
            tot_reg   <= '0;
            dovf_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            line_reg  <= line_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            dt_reg    <= dt_next;
            da_reg    <= da_next;
            pt_reg    <= pt_next;
            pa_reg    <= pa_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
            tot_reg   <= tot_next;
            dovf_reg  <= dovf_next;
        end
    end

    pdc_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (note_val),
        .re    (ram_re),
        .raddr (k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    pdc_queue #(
        .WIDTH($bits(pdc_pkg::out_item_t)),
        .DEPTH(2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign result = pdc_pkg::out_item_t'(res_rdata);

`ifndef NO_ASSERTIONS
    a_push_only_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (state_reg == ST_PUSH))
        else $error("result transfer outside dump");

    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && is_last) |=> (state_reg == ST_IDLE))
        else $error("dump did not end after last digit");

    a_dump_clears: assert property (@(posedge clk) disable iff (!rst_n)
        dump_start |=> (cnt_reg == '0) && !da_reg && !pa_reg
                        && (line_reg == pdc_pkg::LINE_INACTIVE))
        else $error("state not cleared at dump");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (k_reg < tot_reg))
        else $error("store read past number");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("stored count past depth");
`endif

endmodule

// ===== src/pulse_and_tone_dial_collector_top.sv =====
// Top level of the pulse and tone dial collector.
// Depends on pdc_pkg, pdc_front and pdc_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------
//  input    | push / full          | item   (pdc_pkg::in_item_t)
//  results  | pop / empty          | result (pdc_pkg::out_item_t)
//  config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per cycle is taken while no number is being emitted; a two-entry
// command queue sits between the classifier and the collector.
// A tick that completes a number starts a dump: each stored digit is read
// from the store, then written as a result; an empty number gives a marker.
// The collector stalls on a full result queue; input stalls once the
// command queue fills. Reset is asynchronous, active low; no clearing pass.
module pulse_and_tone_dial_collector_top #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  pdc_pkg::in_item_t                    item,
    output logic                                 empty,
    input  logic                                 pop,
    output pdc_pkg::out_item_t                   result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [15:0]                          cfg_data
);

    logic [15:0]   digit_to_reg;
    logic [15:0]   pulse_to_reg;
    pdc_pkg::cfg_t cfg;
    logic          cmd_valid;
    logic          cmd_take;
    pdc_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_to_reg <= pdc_pkg::DIGIT_TIMEOUT_RESET;
            pulse_to_reg <= pdc_pkg::PULSE_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pdc_pkg::CFG_DIGIT_TIMEOUT: digit_to_reg <= cfg_data;
                pdc_pkg::CFG_PULSE_TIMEOUT: pulse_to_reg <= cfg_data;
                default:
                begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign cfg = pdc_pkg::cfg_t'{digit_timeout: digit_to_reg, pulse_timeout: pulse_to_reg};

    pdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    pdc_back #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== tb/dial_result_checker.sv =====
// Checker for the pulse and tone dial collector: watches all three channels,
// predicts each completed number and compares every result transfer.
// Depends on pdc_pkg for the item types, kind codes and register indexes.
module dial_result_checker #(
    parameter int MAX_DIGITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  pdc_pkg::in_item_t                    item,
    input  logic                                 pop,
    input  logic                                 empty,
    input  pdc_pkg::out_item_t                   result,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [pdc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [15:0]                          cfg_data,
    output int                                   fails,
    output int                                   pending
);

    localparam int DEPTH = (MAX_DIGITS < pdc_pkg::STORE_CAP) ? MAX_DIGITS : pdc_pkg::STORE_CAP;

    logic [15:0] digit_limit;
    logic [15:0] pulse_limit;

    logic [1:0]  line;
    logic [3:0]  pulses;
    logic [7:0]  number_digits [pdc_pkg::STORE_CAP];
    int unsigned held;
    logic [15:0] digit_left;
    logic [15:0] pulse_left;
    logic        digit_run;
    logic        pulse_run;
    logic        dropped;

    pdc_pkg::out_item_t digits_due [$];
    pdc_pkg::out_item_t want;
    int                 fail_count = 0;

    task automatic clear_line();
        line       = pdc_pkg::LINE_INACTIVE;
        pulses     = '0;
        held       = 0;
        digit_left = '0;
        digit_run  = 1'b0;
        pulse_left = '0;
        pulse_run  = 1'b0;
        dropped    = 1'b0;
    endtask

    task automatic keep_digit(input logic [7:0] d);
        if (held < DEPTH)
        begin
            number_digits[held] = d;
            held++;
        end
        else
        begin
            dropped = 1'b1;
        end
        digit_left = digit_limit;
        digit_run  = 1'b1;
    endtask

    task automatic emit_number();
        pdc_pkg::out_item_t r;
        if (held == 0)
        begin
            // empty number: one marker result
            r.digit_value      = '0;
            r.digit_position   = '0;
            r.digit_total      = '0;
            r.last_digit       = 1'b1;
            r.store_overflowed = dropped;
            digits_due.push_back(r);
        end
        else
        begin
            for (int k = 0; k < held; k++)
            begin
                r.digit_value      = number_digits[k];
                r.digit_position   = 4'(k);
                r.digit_total      = 5'(held);
                r.last_digit       = (k + 1 == held);
                r.store_overflowed = dropped;
                digits_due.push_back(r);
            end
        end
        clear_line();
    endtask

    task automatic apply_event(input pdc_pkg::in_item_t it);
        logic noted;
        noted = 1'b0;
        case (it.kind)
            pdc_pkg::KIND_TICK:
            begin
                // pulse timer first; a digit it notes rearms the inter-digit timer
                if (pulse_run)
                begin
                    if (pulse_left <= 16'd1)
                    begin
                        pulse_left = '0;
                        pulse_run  = 1'b0;
                        if (line == pdc_pkg::LINE_DOWN)
                        begin
                            line = pdc_pkg::LINE_INACTIVE;
                        end
                        else
                        begin
                            if (pulses != 0)
                            begin
                                keep_digit((pulses < pdc_pkg::PULSE_WRAP) ?
                                           {4'd0, pulses} : 8'd0);
                                noted = 1'b1;
                            end
                            pulses = '0;
                        end
                    end
                    else
                    begin
                        pulse_left = pulse_left - 16'd1;
                    end
                end
                if (digit_run && !noted)
                begin
                    if (digit_left <= 16'd1)
                    begin
                        digit_left = '0;
                        digit_run  = 1'b0;
                        emit_number();
                    end
                    else
                    begin
                        digit_left = digit_left - 16'd1;
                    end
                end
            end
            pdc_pkg::KIND_HOOK:
            begin
                case (line)
                    pdc_pkg::LINE_INACTIVE:
                    begin
                        if (!it.hook_on)
                            line = pdc_pkg::LINE_ACTIVE;
                    end
                    pdc_pkg::LINE_ACTIVE:
                    begin
                        if (it.hook_on)
                        begin
                            line       = pdc_pkg::LINE_DOWN;
                            pulse_left = pulse_limit;
                            pulse_run  = 1'b1;
                        end
                    end
                    default:
                    begin
                        // back off-hook: one dial pulse
                        if (!it.hook_on)
                        begin
                            digit_left = digit_limit;
                            digit_run  = 1'b1;
                            if (pulses < pdc_pkg::PULSE_MAX)
                                pulses = pulses + 4'd1;
                            line = pdc_pkg::LINE_ACTIVE;
                        end
                    end
                endcase
            end
            pdc_pkg::KIND_TONE:
            begin
                if (line == pdc_pkg::LINE_ACTIVE)
                    keep_digit(it.tone_code);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_limit = pdc_pkg::DIGIT_TIMEOUT_RESET;
            pulse_limit = pdc_pkg::PULSE_TIMEOUT_RESET;
            clear_line();
            digits_due.delete();
            pending <= 0;
            fails   <= fail_count;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (digits_due.size() == 0)
                begin
                    $display("%0t: unexpected result transfer: %s %0d %0d %0d %0d %0d",
                             $time, "value/pos/total/last/ovf",
                             result.digit_value, result.digit_position,
                             result.digit_total, result.last_digit,
                             result.store_overflowed);
                    fail_count++;
                end
                else
                begin
                    want = digits_due.pop_front();
                    if (result.digit_value !== want.digit_value
                        || result.digit_position !== want.digit_position
                        || result.digit_total !== want.digit_total
                        || result.last_digit !== want.last_digit
                        || result.store_overflowed !== want.store_overflowed)
                    begin
                        $display("%0t: digit result wrong: expected value %0d pos %0d %s",
                                 $time, want.digit_value, want.digit_position,
                                 "(see below)");
                        $display("    expected total %0d last %0d ovf %0d",
                                 want.digit_total, want.last_digit,
                                 want.store_overflowed);
                        $display("    got value %0d pos %0d total %0d last %0d ovf %0d",
                                 result.digit_value, result.digit_position,
                                 result.digit_total, result.last_digit,
                                 result.store_overflowed);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pdc_pkg::CFG_DIGIT_TIMEOUT: digit_limit = cfg_data;
                    pdc_pkg::CFG_PULSE_TIMEOUT: pulse_limit = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (push && !full)
                apply_event(item);
            pending <= digits_due.size();
            fails   <= fail_count;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Stimulus and verdict for the pulse and tone dial collector.
// Depends on pdc_pkg, pulse_and_tone_dial_collector_top and dial_result_checker.
module testbench;

    localparam int LIMIT        = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 20;

    logic                            clk;
    logic                            rst_n     = 1'b0;
    logic                            push      = 1'b0;
    logic                            pop       = 1'b0;
    pdc_pkg::in_item_t               item      = '0;
    logic                            cfg_valid = 1'b0;
    logic [pdc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]                     cfg_data  = '0;
    logic                            full;
    logic                            empty;
    logic                            cfg_ready;
    pdc_pkg::out_item_t              result;

    int fails;
    int pending;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_tag     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int cycles       = 0;
    int items_sent   = 0;

    logic [15:0] cur_dto;
    logic [15:0] cur_pto;

    pulse_and_tone_dial_collector_top #(
        .MAX_DIGITS(16)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    dial_result_checker #(
        .MAX_DIGITS(16)
    ) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .pop      (pop),
        .empty    (empty),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .fails    (fails),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("pulse_and_tone_dial_collector_top: mismatch");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_tag != hold_seen)
        begin
            hold_seen = hold_tag;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic pdc_pkg::in_item_t mk(input logic [1:0] k, input logic h,
                                             input logic [7:0] c);
        pdc_pkg::in_item_t it;
        it.kind      = k;
        it.hook_on   = h;
        it.tone_code = c;
        return it;
    endfunction

    // Offer one item and hold it until the transfer
    task automatic offer(input pdc_pkg::in_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic ticks(input int n);
        repeat (n)
            offer(mk(pdc_pkg::KIND_TICK, 1'($urandom), 8'($urandom)));
    endtask

    task automatic hook(input logic on);
        offer(mk(pdc_pkg::KIND_HOOK, on, 8'($urandom)));
    endtask

    task automatic tone(input logic [7:0] code);
        offer(mk(pdc_pkg::KIND_TONE, 1'($urandom), code));
    endtask

    task automatic noise();
        offer(mk(2'($urandom_range(3)), 1'($urandom), 8'($urandom)));
    endtask

    // Drop push and wait until every result is out and the block has settled
    task automatic wait_quiet();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12)
            @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] dto, input logic [15:0] pto);
        cfg_valid <= 1'b1;
        cfg_index <= pdc_pkg::CFG_DIGIT_TIMEOUT;
        cfg_data  <= dto;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= pdc_pkg::CFG_PULSE_TIMEOUT;
        cfg_data  <= pto;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_dto = dto;
        cur_pto = pto;
    endtask

    // Off-hook, tone digits and pulse trains with some noise, an optional hang-up, then the quiet period
    task automatic dial_number();
        int nd;
        int np;
        hook(1'b0);
        nd = ($urandom_range(9) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 5);
        repeat (nd)
        begin
            if ($urandom_range(2) != 0)
            begin
                tone(8'($urandom_range(255)));
            end
            else
            begin
                np = ($urandom_range(4) == 0) ? $urandom_range(10, 17) : $urandom_range(1, 9);
                repeat (np)
                begin
                    hook(1'b1);
                    ticks($urandom_range(0, int'(cur_pto) - 1));
                    hook(1'b0);
                end
                ticks(int'(cur_pto));
            end
            if ($urandom_range(15) == 0)
                noise();
        end
        if ($urandom_range(3) == 0)
        begin
            // hang up before the number completes
            hook(1'b1);
            ticks(int'(cur_pto) + $urandom_range(0, 2));
        end
        ticks(int'(cur_dto) + $urandom_range(0, 2));
    endtask

    initial
    begin
        int start;
        logic [15:0] phase_dto [4];
        logic [15:0] phase_pto [4];
        int          phase_tx  [4];
        int          phase_rx  [4];

        phase_dto = '{16'd1, 16'd9, 16'd2, 16'd14};
        phase_pto = '{16'd1, 16'd3, 16'd6, 16'd4};
        phase_tx  = '{0, 76, 0, 8};
        phase_rx  = '{0, 0, 76, 8};
        cur_dto   = pdc_pkg::DIGIT_TIMEOUT_RESET;
        cur_pto   = pdc_pkg::PULSE_TIMEOUT_RESET;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored events, tone extremes, pulses, both timers, hang-up
        configure(16'd3, 16'd2);
        ticks(1);
        offer(mk(pdc_pkg::KIND_IGNORED, 1'b1, 8'hFF));
        tone(8'hFF);
        hook(1'b1);
        hook(1'b0);
        tone(8'h00);
        tone(8'hFF);
        hook(1'b0);
        hook(1'b1);
        hook(1'b1);
        hook(1'b0);
        tone(8'h5A);
        ticks(5);
        hook(1'b0);
        hook(1'b1);
        ticks(3);
        wait_quiet();

        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = phase_tx[ph];
            rx_stall_pct = phase_rx[ph];
            configure(phase_dto[ph], phase_pto[ph]);
            if (ph == 0)
            begin
                // hold off the result side while a full number is dumped
                hold_tag <= hold_tag + 1;
                hook(1'b0);
                repeat (20)
                    tone(8'($urandom_range(255)));
                ticks(int'(cur_dto) + 1);
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(1, 4))
                        noise();
                else
                    dial_number();
            end
            ticks(int'(cur_dto) + int'(cur_pto) + 2);
            wait_quiet();
        end

        // Largest timeouts: load both timers at full count with a tone and one pulse
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        configure(16'hFFFF, 16'hFFFF);
        hook(1'b0);
        tone(8'hA5);
        hook(1'b1);
        hook(1'b0);
        ticks(4);

        wait_quiet();
        repeat (20)
            @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("pulse_and_tone_dial_collector_top: match");
        else
            $display("pulse_and_tone_dial_collector_top: mismatch");
        $finish;
    end

endmodule
